>>> src/mpq_pkg.sv
package mpq_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_UP_CMP  = 6'b000010,
        ST_LAST_RD = 6'b000100,
        ST_DN_CMP  = 6'b001000,
        ST_WR_FIN  = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

endpackage

>>> src/mpq_ram.sv
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> src/min_priority_queue_top.sv
// Bounded min-priority queue of signed keys held as a binary min-heap in one
// two-read, one-write RAM with registered read. Each transfer in either
// inserts a key or removes the smallest one and yields one result: the
// removed key, the new minimum, the entry count and a status (remove on empty
// or insert on full is dropped and flagged). Items are handled one at a time.
// An insert reads the parent and climbs one level per step of the sift loop;
// a remove reads the last key and, when more than one key stays, sinks it one
// level per step. Each step waits on the registered RAM read. A rejected item,
// an insert into an empty queue and a remove of the last key skip the loop.
// The next item is taken while a result waits in the output register.
module min_priority_queue_top #(
    parameter int CAPACITY = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  mpq_pkg::key_t                      key,
    output logic                               out_valid,
    input  logic                               out_ready,
    output mpq_pkg::key_t                      removed_key,
    output mpq_pkg::key_t                      min_key,
    output logic [$clog2(CAPACITY+1)-1:0]      entry_count,
    output logic [1:0]                         status
);

    import mpq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = CNT_W + 1;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    key_t                v_reg, v_next;
    key_t                root_reg;
    key_t                removed_reg, removed_next;
    status_t             status_reg, status_next;

    logic                out_valid_reg, out_valid_next;
    key_t                out_removed_reg;
    key_t                out_min_reg;
    logic [CNT_W-1:0]    out_count_reg;
    status_t             out_status_reg;
    logic                out_load;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    key_t                ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr_a;
    logic [ADDR_W-1:0]   ram_raddr_b;
    key_t                ram_rdata_a;
    key_t                ram_rdata_b;

    logic                accept;
    logic [CNT_W-1:0]    in_parent;
    logic [CNT_W-1:0]    parent;
    logic [CNT_W-1:0]    grand;
    logic [IDX_W-1:0]    count_ext;
    logic [IDX_W-1:0]    child_l;
    logic [IDX_W-1:0]    child_r;
    logic                use_r;
    logic [IDX_W-1:0]    child;
    logic [CNT_W-1:0]    child_pos;
    key_t                child_val;
    logic [IDX_W-1:0]    next_l;
    logic [IDX_W-1:0]    next_r;

    mpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign in_parent = (count_reg - 1'b1) >> 1;
    assign parent    = (pos_reg - 1'b1) >> 1;
    assign grand     = (parent - 1'b1) >> 1;
    assign count_ext = {1'b0, count_reg};
    assign child_l   = {pos_reg, 1'b1};
    assign child_r   = child_l + 1'b1;
    assign use_r     = (child_r < count_ext) && (ram_rdata_b < ram_rdata_a);
    assign child     = use_r ? child_r : child_l;
    assign child_val = use_r ? ram_rdata_b : ram_rdata_a;
    assign child_pos = child[CNT_W-1:0];
    assign next_l    = {child_pos, 1'b1};
    assign next_r    = next_l + 1'b1;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        v_next       = v_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg[ADDR_W-1:0];
        ram_wdata    = v_reg;
        ram_raddr_a  = '0;
        ram_raddr_b  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    removed_next = '0;
                    status_next  = STATUS_OK;
                    if (operation == OP_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            v_next     = key;
                            pos_next   = count_reg;
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = key;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                ram_raddr_a = in_parent[ADDR_W-1:0];
                                state_next  = ST_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            removed_next = root_reg;
                            count_next   = count_reg - 1'b1;
                            if (count_reg == CNT_W'(1))
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                ram_raddr_a = ADDR_W'(count_reg - 1'b1);
                                state_next  = ST_LAST_RD;
                            end
                        end
                    end
                end
            end

            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (v_reg < ram_rdata_a)
                begin
                    ram_wdata = ram_rdata_a;
                    pos_next  = parent;
                    if (parent == '0)
                    begin
                        state_next = ST_WR_FIN;
                    end
                    else
                    begin
                        ram_raddr_a = grand[ADDR_W-1:0];
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_LAST_RD:
            begin
                v_next   = ram_rdata_a;
                pos_next = '0;
                if (count_reg > CNT_W'(1))
                begin
                    ram_raddr_a = ADDR_W'(IDX_W'(1));
                    ram_raddr_b = ADDR_W'(IDX_W'(2));
                    state_next  = ST_DN_CMP;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = ram_rdata_a;
                    state_next = ST_DONE;
                end
            end

            ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (child_val < v_reg)
                begin
                    ram_wdata = child_val;
                    pos_next  = child_pos;
                    if (next_l < count_ext)
                    begin
                        ram_raddr_a = next_l[ADDR_W-1:0];
                        ram_raddr_b = next_r[ADDR_W-1:0];
                    end
                    else
                    begin
                        state_next = ST_WR_FIN;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_WR_FIN:
            begin
                ram_we     = 1'b1;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        v_reg       <= v_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        if (ram_we && (ram_waddr == '0))
        begin
            root_reg <= ram_wdata;
        end
        if (out_load)
        begin
            out_removed_reg <= removed_reg;
            out_min_reg     <= (count_reg != '0) ? root_reg : '0;
            out_count_reg   <= count_reg;
            out_status_reg  <= status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign removed_key = out_removed_reg;
    assign min_key     = out_min_reg;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;

endmodule

>>> src/mpq_checker.sv
module mpq_port_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  mpq_pkg::key_t                 removed_key,
    input  mpq_pkg::key_t                 min_key,
    input  logic [$clog2(CAPACITY+1)-1:0] entry_count,
    input  logic [1:0]                    status
);

    import mpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(removed_key)
            && $stable(min_key) && $stable(entry_count) && $stable(status))
        else $error("stalled result changed");

    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_EMPTY) |->
            (entry_count == '0) && (removed_key == '0) && (min_key == '0))
        else $error("remove on empty reports a non-empty queue");

    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FULL) |->
            (entry_count == CNT_W'(CAPACITY)) && (removed_key == '0))
        else $error("insert on full reports a queue that is not full");

    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (entry_count == '0) |-> (min_key == '0))
        else $error("empty queue reports a minimum");

endmodule

bind min_priority_queue_top mpq_port_checker #(
    .CAPACITY (CAPACITY)
) u_mpq_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .removed_key (removed_key),
    .min_key     (min_key),
    .entry_count (entry_count),
    .status      (status)
);
